/* rtl/double_ended_queue_indexed_unit_defines.svh */
// Assertion macros shared by the checker of the double-ended queue block.
`ifndef DOUBLE_ENDED_QUEUE_INDEXED_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_INDEXED_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DQI_ASSERT_IMP(name, c, r, ante, cons) \
  name: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("dqi checker: implication failed");

// Next-cycle implication, disabled during reset.
`define DQI_ASSERT_NXT(name, c, r, ante, cons) \
  name: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("dqi checker: next-cycle implication failed");

`endif

/* rtl/dqi_pkg.sv */
// Types, codes and constants of the double-ended queue block.
package dqi_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int WORD_W        = 32;
  localparam int MODE_W        = 3;
  localparam int IDX_W         = 8;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 9;

  localparam logic signed [WORD_W-1:0] BAD_INDEX_WORD = -32'sd1000;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ       = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                     shift_right;
    logic                     shift_left;
    logic                     put;
    logic                     tap_load;
    logic                     tap_shift;
    logic signed [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

/* rtl/dqi_if.sv */
// Request and response stream interfaces of the double-ended queue block.
interface dqi_req_if;
  logic                             valid;
  logic                             ready;
  logic [dqi_pkg::MODE_W-1:0]       mode;
  logic signed [dqi_pkg::WORD_W-1:0] value;
  logic [dqi_pkg::IDX_W-1:0]        index;

  modport source (output valid, output mode, output value, output index, input ready);
  modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

interface dqi_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [dqi_pkg::WORD_W-1:0] data;
  logic [dqi_pkg::STATUS_W-1:0]      status;
  logic [dqi_pkg::COUNT_W-1:0]       count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

/* rtl/dqi_cell.sv */
// One queue cell: holds the entry at its position and a read tap passed toward the front.
module dqi_cell #(
  parameter int DEPTH = dqi_pkg::DEPTH_DEFAULT,
  parameter int ID    = 0
) (
  input  logic                              clk,
  input  dqi_pkg::cell_ctl_t                ctl,
  input  logic [$clog2(DEPTH+1)-1:0]        tail,
  input  logic signed [dqi_pkg::WORD_W-1:0] left_word,
  input  logic signed [dqi_pkg::WORD_W-1:0] right_word,
  input  logic signed [dqi_pkg::WORD_W-1:0] right_tap,
  output logic signed [dqi_pkg::WORD_W-1:0] word,
  output logic signed [dqi_pkg::WORD_W-1:0] tap
);

  localparam int CW = $clog2(DEPTH + 1);

  always_ff @(posedge clk) begin
    if (ctl.shift_right) begin
      word <= left_word;
    end else if (ctl.shift_left) begin
      word <= right_word;
    end else if (ctl.put && (tail == CW'(ID))) begin
      word <= ctl.word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tap_load) begin
      tap <= word;
    end else if (ctl.tap_shift) begin
      tap <= right_tap;
    end
  end

endmodule

/* rtl/dqi_ctrl.sv */
// Queue controller: count, request decode, tap walk sequencing and response register.
module dqi_ctrl #(
  parameter int DEPTH = dqi_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  dqi_req_if.sink                           req,
  dqi_rsp_if.source                         rsp,
  input  logic signed [dqi_pkg::WORD_W-1:0] head,
  input  logic signed [dqi_pkg::WORD_W-1:0] tap0,
  output dqi_pkg::cell_ctl_t                ctl,
  output logic [$clog2(DEPTH+1)-1:0]        tail
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > dqi_pkg::IDX_W) ? CW : dqi_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t                            state, state_next;
  logic [CW-1:0]                     cnt, cnt_next;
  logic [CW-1:0]                     rem, rem_next;
  logic                              out_valid;
  logic signed [dqi_pkg::WORD_W-1:0] out_data;
  logic [dqi_pkg::STATUS_W-1:0]      out_status;
  logic [dqi_pkg::COUNT_W-1:0]       out_count;

  logic                              acc, full, empty, idx_ok;
  logic                              out_load, seek;
  logic [CW-1:0]                     target;
  logic signed [dqi_pkg::WORD_W-1:0] res_data;
  dqi_pkg::status_t                  res_status;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign full      = (cnt == CW'(DEPTH));
  assign empty     = (cnt == '0);
  assign idx_ok    = (XW'(req.index) < XW'(cnt));
  assign tail      = cnt;

  always_comb begin
    ctl        = '0;
    ctl.word   = req.value;
    cnt_next   = cnt;
    rem_next   = rem;
    state_next = state;
    out_load   = 1'b0;
    seek       = 1'b0;
    target     = '0;
    res_data   = '0;
    res_status = dqi_pkg::ST_OK;

    if (state == S_WALK) begin
      if (rem != '0) begin
        ctl.tap_shift = 1'b1;
        rem_next      = rem - CW'(1);
      end else begin
        res_data   = tap0;
        out_load   = 1'b1;
        state_next = S_IDLE;
      end
    end

    if (acc) begin
      out_load = 1'b1;
      unique case (dqi_pkg::mode_t'(req.mode))
        dqi_pkg::MODE_PUSH_FRONT: begin
          if (full) begin
            res_status = dqi_pkg::ST_FULL;
          end else begin
            ctl.shift_right = 1'b1;
            cnt_next        = cnt + CW'(1);
          end
        end
        dqi_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            res_status = dqi_pkg::ST_FULL;
          end else begin
            ctl.put  = 1'b1;
            cnt_next = cnt + CW'(1);
          end
        end
        dqi_pkg::MODE_POP_FRONT: begin
          if (empty) begin
            res_status = dqi_pkg::ST_EMPTY;
          end else begin
            res_data       = head;
            ctl.shift_left = 1'b1;
            cnt_next       = cnt - CW'(1);
          end
        end
        dqi_pkg::MODE_POP_BACK: begin
          if (empty) begin
            res_status = dqi_pkg::ST_EMPTY;
          end else begin
            seek     = 1'b1;
            target   = cnt - CW'(1);
            cnt_next = cnt - CW'(1);
          end
        end
        dqi_pkg::MODE_READ: begin
          if (idx_ok) begin
            seek   = 1'b1;
            target = CW'(req.index);
          end else begin
            res_data   = dqi_pkg::BAD_INDEX_WORD;
            res_status = dqi_pkg::ST_EMPTY;
          end
        end
        default: begin
        end
      endcase

      // Front entry answers at once; deeper ones walk the tap chain.
      if (seek) begin
        if (target == '0) begin
          res_data = head;
        end else begin
          out_load      = 1'b0;
          ctl.tap_load  = 1'b1;
          rem_next      = target;
          state_next    = S_WALK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data   <= res_data;
      out_status <= res_status;
      out_count  <= dqi_pkg::COUNT_W'(cnt_next);
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;
  assign rsp.count  = out_count;

endmodule

/* rtl/double_ended_queue_indexed_unit.sv */
// Top level of the double-ended queue: controller and a chain of entry cells.
//
// Bounded double-ended queue of signed 32-bit words, DEPTH entries, held in a row of
// cells ordered from the front. A push at the front or a pop from the front shifts the
// whole row by one cell; a push at the back writes the cell at the tail.
// Every request yields one response with data, status and the count after the request;
// the response sits in an output register until taken. Pushes, pops from the front,
// reads of the front entry and a pop from the back of a queue holding one entry load
// that register directly. A read at distance k >= 1 from the front, or a pop from the
// back with k = count - 1 >= 1, first copies the row into a tap chain that moves one
// cell toward the front each cycle until the entry reaches cell 0 and is registered.
// No new request is taken during that walk. Cells carry no reset, so there is no
// clearing pass; the count is cleared by reset.
module double_ended_queue_indexed_unit #(
  parameter int DEPTH = dqi_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  dqi_req_if.sink   req,
  dqi_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  dqi_pkg::cell_ctl_t                ctl;
  logic [CW-1:0]                     tail;
  logic signed [dqi_pkg::WORD_W-1:0] words [DEPTH];
  logic signed [dqi_pkg::WORD_W-1:0] taps  [DEPTH];

  dqi_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .head (words[0]),
    .tap0 (taps[0]),
    .ctl  (ctl),
    .tail (tail)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dqi_pkg::WORD_W-1:0] left_word;
    logic signed [dqi_pkg::WORD_W-1:0] right_word;
    logic signed [dqi_pkg::WORD_W-1:0] right_tap;

    if (i == 0) begin : g_first
      assign left_word = ctl.word;
    end else begin : g_inner_l
      assign left_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
      assign right_tap  = '0;
    end else begin : g_inner_r
      assign right_word = words[i+1];
      assign right_tap  = taps[i+1];
    end

    dqi_cell #(
      .DEPTH (DEPTH),
      .ID    (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .tail       (tail),
      .left_word  (left_word),
      .right_word (right_word),
      .right_tap  (right_tap),
      .word       (words[i]),
      .tap        (taps[i])
    );
  end

endmodule

/* rtl/dqi_checker.sv */
// Port-level checker of the double-ended queue block, bound to the top level.
`include "double_ended_queue_indexed_unit_defines.svh"

module dqi_checker #(
  parameter int DEPTH = dqi_pkg::DEPTH_DEFAULT
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [dqi_pkg::WORD_W-1:0] rsp_data,
  input logic [dqi_pkg::STATUS_W-1:0]      rsp_status,
  input logic [dqi_pkg::COUNT_W-1:0]       rsp_count
);

  // Hold a stalled response beat.
  `DQI_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

  // Take no request while the response register is blocked.
  `DQI_ASSERT_IMP(a_no_accept_blocked, clk, rst, rsp_valid && !rsp_ready, !req_ready)

  // A dropped push only happens when the queue is full.
  `DQI_ASSERT_IMP(a_full_count, clk, rst, rsp_valid && (rsp_status == dqi_pkg::ST_FULL), rsp_count == dqi_pkg::COUNT_W'(DEPTH))

  // An empty status that is not a bad read comes from a pop on an empty queue.
  `DQI_ASSERT_IMP(a_empty_pop, clk, rst, rsp_valid && (rsp_status == dqi_pkg::ST_EMPTY) && (rsp_data != dqi_pkg::BAD_INDEX_WORD), (rsp_count == '0) && (rsp_data == '0))

endmodule

bind double_ended_queue_indexed_unit dqi_checker #(
  .DEPTH (DEPTH)
) u_dqi_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_data   (rsp.data),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.count)
);
